@@ rtl/tbpq_pkg.sv @@
// Shared types and constants of the three-band priority queue.
`default_nettype none

package tbpq_pkg;

   // Fixed widths of the beat fields.
   localparam int FUNC_W   = 1;
   localparam int PRIO_W   = 6;
   localparam int STATUS_W = 3;
   localparam int BAND_W   = 2;
   localparam int RPRIO_W  = 5;
   localparam int TIME_W   = 16;

   // Operation codes carried in the func field.
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_REMOVED   = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_RANGE     = 3'd4
   } status_type;

   // Controller states.
   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/tbpq_if.sv @@
// Channel interfaces for request and response beats.
`default_nettype none

interface tbpq_req_if;
   logic                        valid;
   logic                        ready;
   logic [tbpq_pkg::FUNC_W-1:0] func;
   logic [tbpq_pkg::PRIO_W-1:0] priority_req;
   logic [tbpq_pkg::TIME_W-1:0] job_time;

   modport source (output valid, output func, output priority_req, output job_time,
                   input ready);
   modport sink   (input valid, input func, input priority_req, input job_time,
                   output ready);
endinterface

interface tbpq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tbpq_pkg::STATUS_W-1:0] status;
   logic [tbpq_pkg::BAND_W-1:0]   band;
   logic [tbpq_pkg::RPRIO_W-1:0]  removed_priority;
   logic [tbpq_pkg::TIME_W-1:0]   removed_time;

   modport source (output valid, output status, output band, output removed_priority,
                   output removed_time, input ready);
   modport sink   (input valid, input status, input band, input removed_priority,
                   input removed_time, output ready);
endinterface

`default_nettype wire

@@ rtl/tbpq_ctrl.sv @@
// Controller state machine: request capture, execution and response valid.
`default_nettype none

module tbpq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tbpq_pkg::cmd_type      cmd
);

   tbpq_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   // The result register can take a new result when empty or drained this cycle.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tbpq_pkg::S_IDLE: begin
            if (req_valid) state_in = tbpq_pkg::S_EXEC;
         end
         tbpq_pkg::S_EXEC: begin
            if (slot_free) state_in = tbpq_pkg::S_IDLE;
         end
         default: begin
            state_in = tbpq_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs and commands.
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         tbpq_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         tbpq_pkg::S_EXEC: begin
            cmd.execute = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Response valid is set by an execution and cleared when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbpq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // An execution never overwrites a result that is still waiting.
   a_exec_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (!rsp_valid_ff || rsp_ready))
      else $error("execute while a result is pending");

   // A new result appears only right after an execution.
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.execute))
      else $error("response valid without execution");

   // An accepted request beat is always followed by the execute state.
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == tbpq_pkg::S_EXEC))
      else $error("accepted beat not executed");

endmodule

`default_nettype wire

@@ rtl/tbpq_dpath.sv @@
// Datapath: request register, occupancy bits, head encoder, time memory, result register.
`default_nettype none

module tbpq_dpath #(
   parameter int NUM_BANDS = 3,
   parameter int BAND_SIZE = 10,
   parameter int TIME_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tbpq_pkg::cmd_type             cmd,
   input  wire logic [tbpq_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [tbpq_pkg::PRIO_W-1:0]   req_priority,
   input  wire logic [tbpq_pkg::TIME_W-1:0]   req_time,
   output logic [tbpq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [tbpq_pkg::BAND_W-1:0]        rsp_band,
   output logic [tbpq_pkg::RPRIO_W-1:0]       rsp_removed_priority,
   output logic [tbpq_pkg::TIME_W-1:0]        rsp_removed_time
);

   localparam int SLOTS = NUM_BANDS * BAND_SIZE;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BIX_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
   localparam int K_W   = (BAND_SIZE > 1) ? $clog2(BAND_SIZE) : 1;

   // Request register.
   logic [tbpq_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [tbpq_pkg::PRIO_W-1:0] prio_ff, prio_in;
   logic [tbpq_pkg::TIME_W-1:0] time_ff, time_in;

   // Occupancy bits and time memory.
   logic [SLOTS-1:0]     occupied_ff, occupied_in;
   logic [TIME_BITS-1:0] time_mem [SLOTS];
   logic [TIME_BITS-1:0] rd_time_ff;

   // Result register.
   tbpq_pkg::status_type        status_ff, status_in;
   logic [tbpq_pkg::BAND_W-1:0]  band_ff, band_in;
   logic [tbpq_pkg::RPRIO_W-1:0] rprio_ff, rprio_in;

   // Decode signals.
   logic                        in_range;
   logic [tbpq_pkg::PRIO_W-1:0] prio_m1;
   logic [IDX_W-1:0]            slot_idx;
   logic [BIX_W-1:0]            band_idx;
   logic [IDX_W-1:0]            band_base;
   logic [BAND_SIZE-1:0]        band_bits;
   logic [K_W-1:0]              head_k;
   logic [IDX_W-1:0]            head_addr;
   logic                        hit;
   logic                        do_write;
   logic                        do_read;

   // Capture the request beat.
   always_comb begin
      func_in = func_ff;
      prio_in = prio_ff;
      time_in = time_ff;
      if (cmd.capture) begin
         func_in = req_func;
         prio_in = req_priority;
         time_in = req_time;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      prio_ff <= prio_in;
      time_ff <= time_in;
   end

   // Range check, slot index and band of the requested priority.
   assign in_range = (prio_ff != '0) && (32'(prio_ff) <= SLOTS);
   assign prio_m1  = prio_ff - tbpq_pkg::PRIO_W'(1);
   assign slot_idx = IDX_W'(prio_m1);
   assign hit      = in_range && occupied_ff[slot_idx];

   always_comb begin
      band_idx = '0;
      for (int j = 1; j < NUM_BANDS; j++) begin
         if (32'(prio_m1) >= 32'(j * BAND_SIZE)) band_idx = BIX_W'(j);
      end
   end

   assign band_base = IDX_W'(32'(band_idx) * BAND_SIZE);

   // Gather the band's occupancy bits and find its lowest occupied slot.
   always_comb begin
      for (int k = 0; k < BAND_SIZE; k++) begin
         band_bits[k] = occupied_ff[IDX_W'(32'(band_base) + k)];
      end
   end

   always_comb begin
      head_k = '0;
      for (int k = BAND_SIZE - 1; k >= 0; k--) begin
         if (band_bits[k]) head_k = K_W'(k);
      end
   end

   assign head_addr = IDX_W'(32'(band_base) + 32'(head_k));

   // Outcome of the operation.
   always_comb begin
      if (!in_range) status_in = tbpq_pkg::ST_RANGE;
      else if (func_ff == tbpq_pkg::FUNC_INSERT)
         status_in = hit ? tbpq_pkg::ST_DUPLICATE : tbpq_pkg::ST_INSERTED;
      else
         status_in = hit ? tbpq_pkg::ST_REMOVED : tbpq_pkg::ST_NOT_FOUND;
   end

   assign band_in  = in_range ? tbpq_pkg::BAND_W'(32'(band_idx) + 1) : '0;
   assign rprio_in = (status_in == tbpq_pkg::ST_REMOVED) ?
                     tbpq_pkg::RPRIO_W'(32'(head_addr) + 1) : '0;
   assign do_write = cmd.execute && (status_in == tbpq_pkg::ST_INSERTED);
   assign do_read  = cmd.execute && (status_in == tbpq_pkg::ST_REMOVED);

   // Occupancy update: set on insert, clear the band head on delete.
   always_comb begin
      occupied_in = occupied_ff;
      if (do_write) occupied_in[slot_idx] = 1'b1;
      else if (do_read) occupied_in[head_addr] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= '0;
      end else begin
         occupied_ff <= occupied_in;
      end
   end

   // Time memory: written on insert, head read on delete, read data registered.
   always_ff @(posedge clock) begin
      if (do_write) time_mem[slot_idx] <= TIME_BITS'(time_ff);
      if (do_read) rd_time_ff <= time_mem[head_addr];
   end

   // Result register, loaded by each execution.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         band_ff   <= band_in;
         rprio_ff  <= rprio_in;
      end
   end

   assign rsp_status           = status_ff;
   assign rsp_band             = band_ff;
   assign rsp_removed_priority = rprio_ff;
   assign rsp_removed_time     = (status_ff == tbpq_pkg::ST_REMOVED) ?
                                 tbpq_pkg::TIME_W'(rd_time_ff) : '0;

endmodule

`default_nettype wire

@@ rtl/three_band_priority_queue.sv @@
// Top level of the three-band priority queue.
//
// Holds up to NUM_BANDS*BAND_SIZE jobs keyed by a unique priority 1..NUM_BANDS*BAND_SIZE,
// with lower numbers more urgent. A request beat on req carries func (insert or delete),
// priority_req and job_time. An insert stores the time at the priority; a delete that
// names a present priority removes the lowest occupied priority of that band.
// Every request beat gives exactly one response beat on rsp with status, band,
// removed_priority and removed_time.
// An accepted beat is registered, executed in the execute state once the result register
// is free, and its response is then registered. The two-state sequencer (capture, then
// execute) accepts no new beat until the current one has been executed.
// When the receiver stalls the response is held in its register; the next request is
// still accepted and waits in the execute state until the response is taken.
// Reset clears the occupancy bits, so the queue starts empty.
// Stored times are kept in a memory that needs no clearing pass.
`default_nettype none

module three_band_priority_queue #(
   parameter int NUM_BANDS = 3,
   parameter int BAND_SIZE = 10,
   parameter int TIME_BITS = 16
) (
   input wire logic    clock,
   input wire logic    reset,
   tbpq_req_if.sink    req,
   tbpq_rsp_if.source  rsp
);

   tbpq_pkg::cmd_type cmd;

   // Sequencer.
   tbpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   // Store, head search and result register.
   tbpq_dpath #(
      .NUM_BANDS (NUM_BANDS),
      .BAND_SIZE (BAND_SIZE),
      .TIME_BITS (TIME_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_func             (req.func),
      .req_priority         (req.priority_req),
      .req_time             (req.job_time),
      .rsp_status           (rsp.status),
      .rsp_band             (rsp.band),
      .rsp_removed_priority (rsp.removed_priority),
      .rsp_removed_time     (rsp.removed_time)
   );

endmodule

`default_nettype wire
